// ===== hw/rtl/hsl_to_rgb_converter_assert.svh =====
// Assertion macros for the HSL to RGB converter.
// Both sample on clk_i; the first is quiet while rst_ni is low.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

`define HSLRGB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

`define HSLRGB_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/hslrgb_pkg.sv =====
`timescale 1ns / 1ps

package hslrgb_pkg;

  localparam int unsigned PixW   = 8;   // width of every input and output field
  localparam int unsigned HuePosW = 10; // hue position in units of 1/768
  localparam int unsigned LevelW = 16;  // q and p in units of 2^-16
  localparam int unsigned WeightW = 8;  // ramp weight, 0..128
  localparam int unsigned AccW   = 23;  // channel level in units of 2^-23
  localparam int unsigned NumCh  = 3;

  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  localparam logic [PixW-1:0]    HalfLight   = 8'd128;
  localparam logic [HuePosW-1:0] HueThird    = 10'd256;
  localparam logic [HuePosW-1:0] HueTwoThird = 10'd512;
  localparam logic [HuePosW-1:0] HueFull     = 10'd768;
  localparam logic [HuePosW-1:0] SextHigh    = 10'd128;
  localparam logic [HuePosW-1:0] SextDown    = 10'd384;
  localparam logic [HuePosW-1:0] SextLow     = 10'd512;
  localparam logic [WeightW-1:0] WeightFull  = 8'd128;
  localparam logic [WeightW-1:0] WeightNone  = 8'd0;

  // Load enables, one per pipeline register stage.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } stage_en_t;

  // Weight of the upper level for a hue position: ramp up, high, ramp down, low.
  function automatic logic [WeightW-1:0] hue_weight(input logic [HuePosW-1:0] x);
    logic [HuePosW-1:0] down;
    begin
      down = SextLow - x;
      if (x < SextHigh) begin
        hue_weight = x[WeightW-1:0];
      end else if (x < SextDown) begin
        hue_weight = WeightFull;
      end else if (x < SextLow) begin
        hue_weight = down[WeightW-1:0];
      end else begin
        hue_weight = WeightNone;
      end
    end
  endfunction

endpackage

// ===== hw/rtl/hslrgb_level.sv =====
`timescale 1ns / 1ps

// Stages 1 and 2: lightness times saturation and hue weights, then the
// upper level q, the lower level p and their difference.
module hslrgb_level (
  input  logic                                  clk_i,
  input  hslrgb_pkg::stage_en_t                 en_i,
  input  logic [hslrgb_pkg::PixW-1:0]           hue_i,
  input  logic [hslrgb_pkg::PixW-1:0]           saturation_i,
  input  logic [hslrgb_pkg::PixW-1:0]           lightness_i,
  output logic [hslrgb_pkg::LevelW-1:0]         lo_o,
  output logic [hslrgb_pkg::LevelW-1:0]         diff_o,
  output logic [hslrgb_pkg::NumCh-1:0][hslrgb_pkg::WeightW-1:0] w_o
);

  // stage 1
  logic [2*hslrgb_pkg::PixW-1:0] ls_d, ls_q;
  logic [hslrgb_pkg::PixW-1:0]   l_q, s_q;
  logic [hslrgb_pkg::HuePosW-1:0] xg, xr, xb;
  logic [hslrgb_pkg::NumCh-1:0][hslrgb_pkg::WeightW-1:0] w1_d, w1_q;

  // stage 2
  logic [hslrgb_pkg::LevelW:0]   q_ext, p_ext;
  logic [hslrgb_pkg::LevelW-1:0] q_d, p_d, lo_q, diff_d, diff_q;
  logic [hslrgb_pkg::NumCh-1:0][hslrgb_pkg::WeightW-1:0] w2_q;

  assign ls_d = lightness_i * saturation_i;

  always_comb begin
    xg = {1'b0, hue_i, 1'b0} + {2'b00, hue_i};
    xr = xg + hslrgb_pkg::HueThird;
    if (xr >= hslrgb_pkg::HueFull) begin
      xr = xr - hslrgb_pkg::HueFull;
    end
    xb = (xg >= hslrgb_pkg::HueThird) ? (xg - hslrgb_pkg::HueThird)
                                      : (xg + hslrgb_pkg::HueTwoThird);
    w1_d[hslrgb_pkg::ChRed]   = hslrgb_pkg::hue_weight(xr);
    w1_d[hslrgb_pkg::ChGreen] = hslrgb_pkg::hue_weight(xg);
    w1_d[hslrgb_pkg::ChBlue]  = hslrgb_pkg::hue_weight(xb);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld1) begin
      ls_q <= ls_d;
      l_q  <= lightness_i;
      s_q  <= saturation_i;
      w1_q <= w1_d;
    end
  end

  // Upper level: l*(1+s) below one half, l+s-l*s otherwise.
  always_comb begin
    if (l_q < hslrgb_pkg::HalfLight) begin
      q_ext = {1'b0, l_q, 8'd0} + {1'b0, ls_q};
    end else begin
      q_ext = ({1'b0, l_q, 8'd0} + {1'b0, s_q, 8'd0}) - {1'b0, ls_q};
    end
    q_d    = q_ext[hslrgb_pkg::LevelW-1:0];
    p_ext  = {l_q, 9'd0} - {1'b0, q_d};
    p_d    = p_ext[hslrgb_pkg::LevelW-1:0];
    diff_d = q_d - p_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld2) begin
      lo_q   <= p_d;
      diff_q <= diff_d;
      w2_q   <= w1_q;
    end
  end

  assign lo_o   = lo_q;
  assign diff_o = diff_q;
  assign w_o    = w2_q;

endmodule

// ===== hw/rtl/hslrgb_channel.sv =====
`timescale 1ns / 1ps

// Stages 3 and 4 of one channel: interpolate between the levels, then
// scale by 255 and truncate.
module hslrgb_channel (
  input  logic                              clk_i,
  input  hslrgb_pkg::stage_en_t             en_i,
  input  logic [hslrgb_pkg::LevelW-1:0]     lo_i,
  input  logic [hslrgb_pkg::LevelW-1:0]     diff_i,
  input  logic [hslrgb_pkg::WeightW-1:0]    w_i,
  output logic [hslrgb_pkg::PixW-1:0]       ch_o
);

  localparam int unsigned ProdW  = hslrgb_pkg::LevelW + hslrgb_pkg::WeightW;
  localparam int unsigned ScaleW = hslrgb_pkg::AccW + hslrgb_pkg::PixW;

  logic [ProdW-1:0]               prod;
  logic [hslrgb_pkg::AccW-1:0]    lvl_d, lvl_q;
  logic [ScaleW-1:0]              scaled;
  logic [hslrgb_pkg::PixW-1:0]    ch_d, ch_q;

  assign prod  = diff_i * w_i;
  assign lvl_d = {lo_i, 7'd0} + prod[hslrgb_pkg::AccW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.ld3) begin
      lvl_q <= lvl_d;
    end
  end

  // level * 255 = level * 256 - level
  assign scaled = {lvl_q, 8'd0} - {8'd0, lvl_q};
  assign ch_d   = scaled[ScaleW-1:hslrgb_pkg::AccW];

  always_ff @(posedge clk_i) begin
    if (en_i.ld4) begin
      ch_q <= ch_d;
    end
  end

  assign ch_o = ch_q;

endmodule

// ===== hw/rtl/hsl_to_rgb_converter.sv =====
// HSL to RGB converter, four register stages.
// Items move through stages 1 to 4 in order; valid_o is the stage 4 valid bit.
// Throughput: one item per cycle with ready_i high; deepest logic: 8x8 then 16x8 multipliers.
// Each stage takes a new item when empty or when its item moves on, so bubbles collapse.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data registers keep contents.
`timescale 1ns / 1ps

`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [hslrgb_pkg::PixW-1:0]   hue_i,
  input  logic [hslrgb_pkg::PixW-1:0]   saturation_i,
  input  logic [hslrgb_pkg::PixW-1:0]   lightness_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [hslrgb_pkg::PixW-1:0]   red_o,
  output logic [hslrgb_pkg::PixW-1:0]   green_o,
  output logic [hslrgb_pkg::PixW-1:0]   blue_o
);

  logic [3:0]            v_d, v_q;
  hslrgb_pkg::stage_en_t en;

  logic [hslrgb_pkg::LevelW-1:0] lo, diff;
  logic [hslrgb_pkg::NumCh-1:0][hslrgb_pkg::WeightW-1:0] w;
  logic [hslrgb_pkg::NumCh-1:0][hslrgb_pkg::PixW-1:0] ch;

  // Load a stage when it is empty or its item advances.
  always_comb begin
    en.ld4 = !v_q[3] || ready_i;
    en.ld3 = !v_q[2] || en.ld4;
    en.ld2 = !v_q[1] || en.ld3;
    en.ld1 = !v_q[0] || en.ld2;
    v_d    = v_q;
    if (en.ld1) v_d[0] = valid_i;
    if (en.ld2) v_d[1] = v_q[0];
    if (en.ld3) v_d[2] = v_q[1];
    if (en.ld4) v_d[3] = v_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ready_o = en.ld1;
  assign valid_o = v_q[3];

  hslrgb_level u_level (
    .clk_i        (clk_i),
    .en_i         (en),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .lo_o         (lo),
    .diff_o       (diff),
    .w_o          (w)
  );

  for (genvar c = 0; c < hslrgb_pkg::NumCh; c++) begin : g_ch
    hslrgb_channel u_channel (
      .clk_i  (clk_i),
      .en_i   (en),
      .lo_i   (lo),
      .diff_i (diff),
      .w_i    (w[c]),
      .ch_o   (ch[c])
    );
  end

  assign red_o   = ch[hslrgb_pkg::ChRed];
  assign green_o = ch[hslrgb_pkg::ChGreen];
  assign blue_o  = ch[hslrgb_pkg::ChBlue];

  `HSLRGB_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> (v_q == 4'd0))
  `HSLRGB_ASSERT(a_drain_frees_input, (valid_o && ready_i) |-> ready_o)
  `HSLRGB_ASSERT(a_stalled_stage_keeps, (v_q[1] && !en.ld3) |=> v_q[1])
  `HSLRGB_ASSERT(a_out_hold, (valid_o && !ready_i) |=> (valid_o && $stable(red_o)))

endmodule

// ===== tb/hsl_to_rgb_converter_tb.sv =====
`timescale 1ns / 1ps

module hsl_to_rgb_converter_tb;

  typedef logic [hslrgb_pkg::PixW-1:0] pix_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

  typedef struct packed {
    pix_t hue;
    pix_t sat;
    pix_t light;
    bit   typed;  // expected color below is given by hand
    rgb_t color;
  } pixel_case_t;

  localparam int NumDirected   = 22;
  localparam int NumRandom     = 1630;
  localparam int QuietTail     = 200;
  localparam int MaxReported   = 10;
  localparam int DrainCycles   = 4000;
  localparam int SettleCycles  = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_i = 1'b0;
  pix_t hue_i = '0;
  pix_t saturation_i = '0;
  pix_t lightness_i = '0;
  logic ready_o;
  logic valid_o;
  pix_t red_o;
  pix_t green_o;
  pix_t blue_o;

  rgb_t rgb_pending[$];
  int   mismatches = 0;
  bit   idle_off = 1'b0;
  int   stall_left = 0;

  // Directed pixels: grey, black and white are typed in, the rest goes to the predictor.
  pixel_case_t directed_cases [NumDirected] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd254, 8'd254, 8'd254}},
    '{8'd255, 8'd0,   8'd128, 1'b1, '{8'd127, 8'd127, 8'd127}},
    '{8'd97,  8'd0,   8'd64,  1'b1, '{8'd63,  8'd63,  8'd63}},
    '{8'd200, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{8'd0,   8'd255, 8'd128, 1'b0, '0},
    '{8'd42,  8'd255, 8'd128, 1'b0, '0},
    '{8'd43,  8'd255, 8'd128, 1'b0, '0},
    '{8'd85,  8'd255, 8'd128, 1'b0, '0},
    '{8'd86,  8'd255, 8'd128, 1'b0, '0},
    '{8'd127, 8'd255, 8'd128, 1'b0, '0},
    '{8'd128, 8'd255, 8'd128, 1'b0, '0},
    '{8'd170, 8'd255, 8'd128, 1'b0, '0},
    '{8'd171, 8'd255, 8'd128, 1'b0, '0},
    '{8'd255, 8'd255, 8'd128, 1'b0, '0},
    '{8'd200, 8'd255, 8'd127, 1'b0, '0},
    '{8'd200, 8'd1,   8'd128, 1'b0, '0},
    '{8'd10,  8'd1,   8'd127, 1'b0, '0},
    '{8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{8'd128, 8'd128, 8'd1,   1'b0, '0},
    '{8'd64,  8'd170, 8'd85,  1'b0, '0},
    '{8'd213, 8'd85,  8'd170, 1'b0, '0}
  };

  hsl_to_rgb_converter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .ready_o      (ready_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .valid_o      (valid_o),
    .ready_i      (ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Channel level in units of 2^-23 over the sextants, then scaled by 255 and truncated.
  function automatic pix_t channel_byte(input int unsigned lo, input int unsigned hi,
                                        input int unsigned pos);
    int unsigned level;
    int unsigned scaled;
    begin
      if (pos < 128) begin
        level = 128 * lo + (hi - lo) * pos;
      end else if (pos < 384) begin
        level = 128 * hi;
      end else if (pos < 512) begin
        level = 128 * lo + (hi - lo) * (512 - pos);
      end else begin
        level = 128 * lo;
      end
      scaled = (level * 255) >> 23;
      channel_byte = scaled[hslrgb_pkg::PixW-1:0];
    end
  endfunction

  function automatic rgb_t hsl_to_rgb(input pix_t hue, input pix_t sat, input pix_t light);
    int unsigned h;
    int unsigned s;
    int unsigned l;
    int unsigned upper;
    int unsigned lower;
    int unsigned pos_r;
    int unsigned pos_g;
    int unsigned pos_b;
    int unsigned grey;
    rgb_t        color;
    begin
      h = hue;
      s = sat;
      l = light;
      if (s == 0) begin
        grey = (l * 255) >> 8;
        color.red   = grey[hslrgb_pkg::PixW-1:0];
        color.green = grey[hslrgb_pkg::PixW-1:0];
        color.blue  = grey[hslrgb_pkg::PixW-1:0];
      end else begin
        if (l < 128) begin
          upper = l * (256 + s);
        end else begin
          upper = 256 * (l + s) - l * s;
        end
        lower = 512 * l - upper;
        pos_g = 3 * h;
        pos_r = (pos_g + 256) % 768;
        pos_b = (pos_g + 512) % 768;
        color.red   = channel_byte(lower, upper, pos_r);
        color.green = channel_byte(lower, upper, pos_g);
        color.blue  = channel_byte(lower, upper, pos_b);
      end
      hsl_to_rgb = color;
    end
  endfunction

  // Present one pixel, optionally after an idle burst, and hold it until accepted.
  task automatic send_pixel(input pix_t hue, input pix_t sat, input pix_t light,
                            input bit typed, input rgb_t typed_color);
    int gap;
    begin
      if (!idle_off && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 3);
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      valid_i      <= 1'b1;
      hue_i        <= hue;
      saturation_i <= sat;
      lightness_i  <= light;
      do @(posedge clk_i); while (!ready_o);
      rgb_pending.push_back(typed ? typed_color : hsl_to_rgb(hue, sat, light));
    end
  endtask

  // Output side: check accepted items and throttle ready_i.
  always @(posedge clk_i) begin
    rgb_t want;
    logic ready_next;
    if (rst_ni && valid_o && ready_i) begin
      if (rgb_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("unexpected item: r=%0d g=%0d b=%0d", red_o, green_o, blue_o);
        end
      end else begin
        want = rgb_pending.pop_front();
        if (red_o !== want.red || green_o !== want.green || blue_o !== want.blue) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("rgb mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.red, want.green, want.blue, red_o, green_o, blue_o);
          end
        end
      end
    end
    ready_next = 1'b1;
    if (!rst_ni) begin
      ready_next = 1'b0;
    end else if (!idle_off) begin
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        ready_next = 1'b0;
      end
    end
    ready_i <= ready_next;
  end

  initial begin
    pix_t hue;
    pix_t sat;
    pix_t light;
    int   drain;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cases[i]) begin
      send_pixel(directed_cases[i].hue, directed_cases[i].sat, directed_cases[i].light,
                 directed_cases[i].typed, directed_cases[i].color);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - QuietTail) begin
        idle_off = 1'b1;
      end
      hue = pix_t'($urandom);
      sat = pix_t'($urandom);
      light = pix_t'($urandom);
      case ($urandom_range(0, 9))
        0: sat = '0;
        1: begin
          case ($urandom_range(0, 3))
            0: light = 8'd0;
            1: light = 8'd127;
            2: light = 8'd128;
            default: light = 8'd255;
          endcase
        end
        2: sat = 8'd255;
        default: ;
      endcase
      send_pixel(hue, sat, light, 1'b0, '0);
    end
    valid_i <= 1'b0;

    drain = 0;
    while (rgb_pending.size() != 0 && drain < DrainCycles) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0 && rgb_pending.size() == 0) begin
      $display("hsl_to_rgb_converter verification clean");
    end else begin
      $display("hsl_to_rgb_converter verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("hsl_to_rgb_converter verification failed");
    $finish;
  end

endmodule
